[rtl/core/dd_pkg.sv]
`default_nettype none

package dd_pkg;

	localparam int unsigned DayW   = 5;
	localparam int unsigned MonW   = 4;
	localparam int unsigned YearW  = 14;
	localparam int unsigned CountW = 22;
	localparam int unsigned AccW   = CountW + 1;
	localparam int unsigned RemW   = 9;
	localparam int unsigned AddW   = 9;

	localparam logic [YearW-1:0]  RemBase   = 14'd400;
	localparam int unsigned       ModSteps  = 6;
	localparam logic [CountW-1:0] CountMax  = 22'h3FFFFF;

	localparam logic [MonW-1:0] MonthJan = 4'd1;
	localparam logic [MonW-1:0] MonthFeb = 4'd2;
	localparam logic [MonW-1:0] MonthDec = 4'd12;

	localparam logic [AddW-1:0] DaysYear = 9'd365;
	localparam logic [AddW-1:0] DaysLeap = 9'd366;

	typedef struct packed {
		logic             more;
		logic [DayW-1:0]  day;
		logic [MonW-1:0]  month;
		logic [YearW:0]   year;
		logic [RemW-1:0]  rem;
		logic [AddW-1:0]  addend;
	} dd_step_t;

	// rem is the year modulo 400
	function automatic logic leap_of(input logic [RemW-1:0] rem);
		return (rem == '0) ||
			((rem[1:0] == 2'b00) && (rem != 9'd100) && (rem != 9'd200) && (rem != 9'd300));
	endfunction

	function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m, input logic lp);
		logic [DayW-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			MonthFeb: len = lp ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic earlier(
		input logic [YearW:0]   y1,
		input logic [MonW-1:0]  m1,
		input logic [DayW-1:0]  d1,
		input logic [YearW:0]   y2,
		input logic [MonW-1:0]  m2,
		input logic [DayW-1:0]  d2
	);
		logic r;
		if (y1 != y2) begin
			r = (y1 < y2);
		end else if (m1 != m2) begin
			r = (m1 < m2);
		end else begin
			r = (d1 < d2);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/core/dd_cal_step.sv]
`default_nettype none

module dd_cal_step (
	input  wire logic [dd_pkg::DayW-1:0]  day,
	input  wire logic [dd_pkg::MonW-1:0]  month,
	input  wire logic [dd_pkg::YearW:0]   year,
	input  wire logic [dd_pkg::RemW-1:0]  rem,
	input  wire logic [dd_pkg::DayW-1:0]  end_day,
	input  wire logic [dd_pkg::MonW-1:0]  end_month,
	input  wire logic [dd_pkg::YearW-1:0] end_year,
	output dd_pkg::dd_step_t              step
);
	import dd_pkg::*;

	logic             lp;
	logic [DayW-1:0]  len;
	logic [YearW:0]   y_ext;
	logic [YearW:0]   e_ext;
	logic [YearW:0]   ny;
	logic [RemW-1:0]  nr;
	logic             wrap;
	logic [YearW:0]   nm_year;
	logic [MonW-1:0]  nm_month;
	logic [RemW-1:0]  nm_rem;
	logic             year_ok;
	logic             month_ok;

	always_comb begin
		lp       = leap_of(rem);
		len      = month_len(month, lp);
		y_ext    = year;
		e_ext    = {1'b0, end_year};
		ny       = y_ext + 15'd1;
		nr       = (rem == RemW'(RemBase - 14'd1)) ? '0 : rem + 9'd1;
		wrap     = (month == MonthDec);
		nm_year  = wrap ? ny : y_ext;
		nm_month = wrap ? MonthJan : month + 4'd1;
		nm_rem   = wrap ? nr : rem;
		year_ok  = (day == 5'd1) && (month == MonthJan) &&
			!earlier(e_ext, end_month, end_day, ny, MonthJan, 5'd1);
		month_ok = (day == 5'd1) &&
			!earlier(e_ext, end_month, end_day, nm_year, nm_month, 5'd1);

		step.more   = earlier(y_ext, month, day, e_ext, end_month, end_day);
		step.day    = day;
		step.month  = month;
		step.year   = year;
		step.rem    = rem;
		step.addend = 9'd1;

		// whole year, whole month, or a single day
		if (year_ok) begin
			step.year   = ny;
			step.rem    = nr;
			step.addend = lp ? DaysLeap : DaysYear;
		end else if (month_ok || (day >= len)) begin
			step.day    = 5'd1;
			step.month  = nm_month;
			step.year   = nm_year;
			step.rem    = nm_rem;
			step.addend = month_ok ? {4'b0, len} : 9'd1;
		end else begin
			step.day = day + 5'd1;
		end
	end

endmodule

`default_nettype wire

[rtl/core/date_difference_in_days_top.sv]
// sequence: capture, year mod 400, start check, walk, done; an invalid start skips the walk; from
// day 1 of january a step covers a whole year, from day 1 of a month a whole month,
// when the end date lies far enough ahead, else a single day
// walk steps: up to about 42 + (end_year - start_year) + 42
// a new query is taken only once the previous one has reached the output; a finished
// word may wait at the output while the next is taken
// arst_n clears the sequencer and the output valid; the datapath is not reset
`default_nettype none

module date_difference_in_days_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [dd_pkg::DayW-1:0]   start_day,
	input  wire logic [dd_pkg::MonW-1:0]   start_month,
	input  wire logic [dd_pkg::YearW-1:0]  start_year,
	input  wire logic [dd_pkg::DayW-1:0]   end_day,
	input  wire logic [dd_pkg::MonW-1:0]   end_month,
	input  wire logic [dd_pkg::YearW-1:0]  end_year,
	input  wire logic                      include_end,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [dd_pkg::CountW-1:0]      day_count,
	output logic                           bad_date
);
	import dd_pkg::*;

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StMod  = 3'd1;
	localparam logic [2:0] StChk  = 3'd2;
	localparam logic [2:0] StWalk = 3'd3;
	localparam logic [2:0] StDone = 3'd4;

	logic [2:0]       state_q;
	logic [2:0]       k_q;
	logic [DayW-1:0]  walk_day_q;
	logic [MonW-1:0]  walk_month_q;
	logic [YearW:0]   walk_year_q;
	logic [DayW-1:0]  end_day_q;
	logic [MonW-1:0]  end_month_q;
	logic [YearW-1:0] end_year_q;
	logic             inc_q;
	logic [YearW-1:0] rem_q;
	logic [AccW-1:0]  count_q;
	logic             bad_q;

	logic [YearW-1:0] sub_val;
	logic [AccW-1:0]  fin_sum;
	logic [DayW-1:0]  start_len;
	logic             start_bad;
	dd_step_t         step;

	dd_cal_step u_step (
		.day       (walk_day_q),
		.month     (walk_month_q),
		.year      (walk_year_q),
		.rem       (rem_q[RemW-1:0]),
		.end_day   (end_day_q),
		.end_month (end_month_q),
		.end_year  (end_year_q),
		.step      (step)
	);

	assign in_stall  = (state_q != StIdle);
	assign sub_val   = RemBase << k_q;
	assign fin_sum   = count_q + {{(AccW-1){1'b0}}, inc_q};
	assign start_len = month_len(walk_month_q, leap_of(rem_q[RemW-1:0]));
	assign start_bad = (walk_month_q < MonthJan) || (walk_month_q > MonthDec) ||
		(walk_day_q > start_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= StIdle;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && (state_q != StDone)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				StIdle: begin
					if (in_valid) begin
						state_q <= StMod;
					end
				end
				StMod: begin
					if (k_q == '0) begin
						state_q <= StChk;
					end
				end
				StChk: begin
					state_q <= start_bad ? StDone : StWalk;
				end
				StWalk: begin
					if (!step.more) begin
						state_q <= StDone;
					end
				end
				StDone: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						state_q   <= StIdle;
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			StIdle: begin
				if (in_valid) begin
					walk_day_q   <= start_day;
					walk_month_q <= start_month;
					walk_year_q  <= {1'b0, start_year};
					end_day_q    <= end_day;
					end_month_q  <= end_month;
					end_year_q   <= end_year;
					inc_q        <= include_end;
					rem_q        <= start_year;
					k_q          <= 3'(ModSteps - 1);
					count_q      <= '0;
				end
			end
			StMod: begin
				// year mod 400 by restoring subtraction
				if (rem_q >= sub_val) begin
					rem_q <= rem_q - sub_val;
				end
				k_q <= k_q - 3'd1;
			end
			StChk: begin
				bad_q <= start_bad;
			end
			StWalk: begin
				if (step.more) begin
					walk_day_q   <= step.day;
					walk_month_q <= step.month;
					walk_year_q  <= step.year;
					rem_q        <= {{(YearW-RemW){1'b0}}, step.rem};
					count_q      <= count_q + {{(AccW-AddW){1'b0}}, step.addend};
				end
			end
			StDone: begin
				if (!out_valid || !out_stall) begin
					bad_date <= bad_q;
					if (bad_q) begin
						day_count <= '0;
					end else if (fin_sum > {1'b0, CountMax}) begin
						day_count <= CountMax;
					end else begin
						day_count <= fin_sum[CountW-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StChk) |-> (rem_q < RemBase))
		else $error("year remainder not reduced");

	a_walk_month: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StWalk) |-> ((walk_month_q >= MonthJan) && (walk_month_q <= MonthDec)))
		else $error("walk month out of range");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StWalk && step.more) |=> (count_q > $past(count_q)))
		else $error("walk count did not advance");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_date) |-> (day_count == '0))
		else $error("bad date with nonzero count");

endmodule

`default_nettype wire

[test/date_difference_in_days_top_tb.sv]
`timescale 1ns / 100ps

module date_difference_in_days_top_tb;

	localparam int unsigned CycleLimit   = 2000000;
	localparam int unsigned RandomWords  = 100;
	localparam int unsigned HoldCycles   = 600;
	localparam int unsigned DrainCycles  = 200;

	typedef struct packed {
		logic [dd_pkg::DayW-1:0]  sd;
		logic [dd_pkg::MonW-1:0]  sm;
		logic [dd_pkg::YearW-1:0] sy;
		logic [dd_pkg::DayW-1:0]  ed;
		logic [dd_pkg::MonW-1:0]  em;
		logic [dd_pkg::YearW-1:0] ey;
		logic                     inc;
	} date_query_t;

	typedef struct packed {
		logic [dd_pkg::CountW-1:0] count;
		logic                      bad;
	} span_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [dd_pkg::DayW-1:0]  start_day;
	logic [dd_pkg::MonW-1:0]  start_month;
	logic [dd_pkg::YearW-1:0] start_year;
	logic [dd_pkg::DayW-1:0]  end_day;
	logic [dd_pkg::MonW-1:0]  end_month;
	logic [dd_pkg::YearW-1:0] end_year;
	logic include_end;
	logic out_valid;
	logic out_stall;
	logic [dd_pkg::CountW-1:0] day_count;
	logic bad_date;

	span_word_t  span_queue[$];
	date_query_t table_query[$];
	bit          table_typed[$];
	span_word_t  table_word[$];
	span_word_t  head_word;

	int unsigned cycle_count = 0;
	int unsigned error_count = 0;
	int unsigned words_sent = 0;
	int unsigned words_seen = 0;
	int unsigned bad_seen = 0;
	int unsigned saturated_seen = 0;
	int unsigned input_blocked = 0;
	int unsigned hold_left = 0;
	int unsigned burst_left = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	bit hold_on = 1'b0;

	date_difference_in_days_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.start_day   (start_day),
		.start_month (start_month),
		.start_year  (start_year),
		.end_day     (end_day),
		.end_month   (end_month),
		.end_year    (end_year),
		.include_end (include_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.day_count   (day_count),
		.bad_date    (bad_date)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit leap_year(input int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
		int unsigned n;
		case (m)
			1, 3, 5, 7, 8, 10, 12: n = 31;
			4, 6, 9, 11: n = 30;
			2: n = leap_year(y) ? 29 : 28;
			default: n = 0;
		endcase
		return n;
	endfunction

	// valid dates from year 0 on that lie strictly below y-m-d
	function automatic int unsigned dates_below(input int unsigned y, input int unsigned m,
			input int unsigned d);
		int unsigned n;
		int unsigned full;
		int unsigned len;
		n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
		full = (m == 0) ? 0 : ((m > 12) ? 12 : m - 1);
		for (int unsigned k = 1; k <= full; k++)
			n += month_days(y, k);
		if (m >= 1 && m <= 12 && d >= 1) begin
			len = month_days(y, m);
			n += (d - 1 < len) ? d - 1 : len;
		end
		return n;
	endfunction

	function automatic span_word_t day_span(input date_query_t q);
		int unsigned sd, sm, sy, ed, em, ey;
		int unsigned n;
		bit start_first;
		span_word_t w;
		sd = 32'(q.sd);
		sm = 32'(q.sm);
		sy = 32'(q.sy);
		ed = 32'(q.ed);
		em = 32'(q.em);
		ey = 32'(q.ey);
		n = 0;
		w.bad = 1'b0;
		if (sm < 1 || sm > 12 || sd > month_days(sy, sm)) begin
			w.bad = 1'b1;
		end else begin
			if (sy != ey)
				start_first = sy < ey;
			else if (sm != em)
				start_first = sm < em;
			else
				start_first = sd < ed;
			if (start_first)
				n = 1 + dates_below(ey, em, ed) - (dates_below(sy, sm, sd) + ((sd >= 1) ? 1 : 0));
			n += 32'(q.inc);
			if (n > 32'(dd_pkg::CountMax))
				n = 32'(dd_pkg::CountMax);
		end
		w.count = n[dd_pkg::CountW-1:0];
		return w;
	endfunction

	task automatic add_row(input int unsigned sd, input int unsigned sm, input int unsigned sy,
			input int unsigned ed, input int unsigned em, input int unsigned ey,
			input bit inc, input bit typed, input int unsigned cnt, input bit bad);
		date_query_t q;
		span_word_t w;
		q.sd = 5'(sd);
		q.sm = 4'(sm);
		q.sy = 14'(sy);
		q.ed = 5'(ed);
		q.em = 4'(em);
		q.ey = 14'(ey);
		q.inc = inc;
		w.count = 22'(cnt);
		w.bad = bad;
		table_query.push_back(q);
		table_typed.push_back(typed);
		table_word.push_back(w);
	endtask

	task automatic random_query(input int unsigned idx, output date_query_t q);
		int unsigned sy, sm, sd, ey, em, ed, pick;
		pick = $urandom_range(0, 9);
		sy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(1, 9999);
		if ($urandom_range(0, 7) == 0) begin
			sm = $urandom_range(0, 15);
			sd = $urandom_range(0, 31);
		end else if ($urandom_range(0, 4) == 0) begin
			sm = 1;
			sd = 1;
		end else begin
			sm = $urandom_range(1, 12);
			sd = $urandom_range(1, month_days(sy, sm));
		end
		// a few long spans, the rest up to 80 years long or ending up to 5 years before the start
		if (idx % 30 == 29)
			ey = $urandom_range(sy, 16383);
		else if (pick < 5)
			ey = sy;
		else if (pick < 8)
			ey = sy + $urandom_range(1, 3);
		else if (pick < 9)
			ey = sy + $urandom_range(4, 80);
		else
			ey = (sy > 5) ? sy - $urandom_range(0, 5) : 0;
		if (ey > 16383)
			ey = 16383;
		if ($urandom_range(0, 9) == 0)
			em = $urandom_range(0, 15);
		else
			em = $urandom_range(1, 12);
		if ($urandom_range(0, 9) == 0 || em < 1 || em > 12)
			ed = $urandom_range(0, 31);
		else
			ed = $urandom_range(1, month_days(ey, em));
		q.sd = 5'(sd);
		q.sm = 4'(sm);
		q.sy = 14'(sy);
		q.ed = 5'(ed);
		q.em = 4'(em);
		q.ey = 14'(ey);
		q.inc = 1'($urandom_range(0, 1));
	endtask

	task automatic send_query(input date_query_t q, input span_word_t w);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start_day   <= q.sd;
		start_month <= q.sm;
		start_year  <= q.sy;
		end_day     <= q.ed;
		end_month   <= q.em;
		end_year    <= q.ey;
		include_end <= q.inc;
		in_valid    <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		span_queue.push_back(w);
		words_sent++;
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch on word %0d, %s: got %0d, want %0d", words_seen, what, got, want);
		error_count++;
	endtask

	// result check and random output stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (span_queue.size() == 0) begin
					report_mismatch("unexpected word, day_count", 32'(day_count), 0);
				end else begin
					head_word = span_queue.pop_front();
					if (day_count !== head_word.count)
						report_mismatch("day_count", 32'(day_count), 32'(head_word.count));
					if (bad_date !== head_word.bad)
						report_mismatch("bad_date", 32'(bad_date), 32'(head_word.bad));
					if (head_word.bad)
						bad_seen++;
					if (head_word.count == dd_pkg::CountMax)
						saturated_seen++;
				end
				words_seen++;
			end
			if (burst_left != 0)
				burst_left--;
			else if (idle_on && $urandom_range(0, 5) == 0)
				burst_left = $urandom_range(1, 14);
			out_stall <= hold_on || (burst_left != 0);
		end
	end

	// long receiver hold, so that the block backs up into its input
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_req && !hold_done) begin
				hold_left <= HoldCycles;
				hold_done <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end
			hold_on <= (hold_left != 0);
			if (hold_on && in_stall)
				input_blocked <= input_blocked + 1;
		end
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("date_difference_in_days_top regression: fail");
		$finish;
	end

	initial begin
		date_query_t q;
		span_word_t w;
		int unsigned i;

		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		start_day = '0;
		start_month = '0;
		start_year = '0;
		end_day = '0;
		end_month = '0;
		end_year = '0;
		include_end = 1'b0;

		// start d, m, y | end d, m, y | include | typed | count | bad
		add_row( 1,  1,  2000,  1,  1,  2000, 0, 1, 0, 0);
		add_row( 1,  1,  2000,  1,  1,  2000, 1, 1, 1, 0);
		add_row( 1,  1,  2000,  2,  1,  2000, 0, 1, 1, 0);
		add_row(31, 12,  1999,  1,  1,  2000, 0, 1, 1, 0);
		add_row(28,  2,  2000,  1,  3,  2000, 0, 0, 0, 0);
		add_row(28,  2,  1900,  1,  3,  1900, 1, 0, 0, 0);
		add_row(28,  2,  2004,  1,  3,  2004, 0, 0, 0, 0);
		add_row(29,  2,  2000,  1,  3,  2000, 0, 0, 0, 0);
		add_row(29,  2,  1900,  1,  3,  1900, 1, 1, 0, 1);
		add_row(31,  4,  2021,  1,  5,  2021, 1, 1, 0, 1);
		add_row( 5,  0,  2021,  1,  1,  2022, 1, 1, 0, 1);
		add_row(31, 15, 16383,  0,  0,     0, 1, 1, 0, 1);
		add_row( 1, 13,   100,  1,  1,   200, 0, 1, 0, 1);
		add_row( 0,  3,  2020,  1,  3,  2020, 0, 0, 0, 0);
		add_row( 0,  1,     1, 31, 12,     1, 1, 0, 0, 0);
		add_row(15,  6,  2020,  1,  6,  2020, 0, 1, 0, 0);
		add_row(15,  6,  2021, 14,  6,  2021, 1, 1, 1, 0);
		add_row(20,  2,  2021, 31,  2,  2021, 0, 0, 0, 0);
		add_row(20, 11,  2021,  0, 13,  2021, 1, 0, 0, 0);
		add_row(10,  5,  2021,  0,  0,  2022, 0, 0, 0, 0);
		add_row(28,  2,     0,  1,  3,     0, 0, 0, 0, 0);
		add_row( 1,  1,     0, 31, 12, 16383, 1, 1, 32'(dd_pkg::CountMax), 0);
		add_row( 1,  1,     1, 31, 12,  9999, 1, 0, 0, 0);
		add_row(31, 12, 16383, 31, 15, 16383, 1, 0, 0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < table_query.size(); i++) begin
			w = table_typed[i] ? table_word[i] : day_span(table_query[i]);
			send_query(table_query[i], w);
		end

		for (i = 0; i < RandomWords; i++) begin
			idle_on <= !((i >= 30 && i < 45) || (i >= RandomWords - 15));
			if (i == 55)
				hold_req <= 1'b1;
			random_query(i, q);
			send_query(q, day_span(q));
		end
		in_valid <= 1'b0;

		while (span_queue.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("checked %0d words (%0d from the table), %0d bad starts, %0d saturated counts",
			words_seen, table_query.size(), bad_seen, saturated_seen);
		$display("input stalled for %0d cycles during the receiver hold, %0d cycles in all",
			input_blocked, cycle_count);
		if (error_count == 0)
			$display("date_difference_in_days_top regression: pass");
		else
			$display("date_difference_in_days_top regression: fail");
		$finish;
	end

endmodule
